[sv/rxd_pkg.sv]
// Shared types, codes and constants for the radio receive packet deframer.
package rxd_pkg;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_BYTE    = 2'd1,
    FUNC_POLL    = 2'd2,
    FUNC_TIMEOUT = 2'd3
  } rxd_func_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic REG_MAX_BYTES  = 1'b0;
  localparam logic REG_WAIT_LIMIT = 1'b1;

  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  GLITCH_ONE       = 8'h80;
  localparam logic [7:0]  GLITCH_TWO       = 8'hC0;
  localparam logic [7:0]  RSSI_UNKNOWN     = 8'hFF;
  localparam logic [11:0] MAX_BYTES_RESET  = 12'd255;
  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd1000;

  localparam int RES_PER_ITEM = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic              kind;
    logic [7:0]        payload_byte;
    logic              last;
    logic [11:0]       length;
    logic signed [7:0] rssi_dbm;
    logic [31:0]       packet_total;
  } rxd_result_t;

  typedef struct packed {
    logic [1:0]                          count;
    rxd_result_t [RES_PER_ITEM-1:0]      entry;
  } rxd_push_t;

  // Negated raw RSSI halved toward zero; unknown reads as 0 dBm.
  function automatic logic signed [7:0] dbm_of(input logic [7:0] raw);
    logic [7:0] half;
    begin
      half = {1'b0, raw[7:1]};
      if (raw == RSSI_UNKNOWN) begin
        dbm_of = 8'sd0;
      end else begin
        dbm_of = $signed(8'd0 - half);
      end
    end
  endfunction

endpackage

[sv/radio_rx_packet_deframer.sv]
// An accepted item waits in the input register until the four-entry result queue has room
//   for three more results; its results then go into the queue for the master side.
// Throughput: one item per cycle while each item yields at most one result and the master
//   side, one result per cycle, is ready; items yielding more results hold the input back.
// Reset (rst, synchronous): closes any packet, clears counters, rssi unknown, registers
//   back to max_bytes 255 and wait_limit 1000.
module radio_rx_packet_deframer (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rxd_pkg::CFG_DATA_W-1:0] cfg_data,
  // Slave side: FIFO items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data
  input  logic [1:0]                    s_axis_tuser,  // [1:0] func
  // Master side: results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [19:8] length, [27:20] rssi_dbm, [59:28] packet_total, rest zero
  output logic [63:0]                   m_axis_tdata,
  output logic                          m_axis_tuser,  // [0] kind
  output logic                          m_axis_tlast
);

  // Input register: holds one accepted transaction until the core takes it.
  logic               in_valid;
  rxd_pkg::rxd_func_t in_func;
  logic [7:0]         in_data;
  logic               fire;
  logic               room;

  rxd_pkg::rxd_push_t   push;
  rxd_pkg::rxd_result_t res;

  // Advance the held item whenever the queue can take its worst-case three results.
  assign fire          = in_valid && room;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= rxd_pkg::rxd_func_t'(s_axis_tuser);
      in_data <= s_axis_tdata;
    end
  end

  // Packet state machine and result formation.
  rxd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .func      (in_func),
    .data      (in_data),
    .push      (push)
  );

  // Result queue parting the core from the master side.
  rxd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {4'd0, res.packet_total, res.rssi_dbm, res.length,
                         res.payload_byte};

endmodule

[sv/rxd_core.sv]
// Packet state, configuration registers and per-item result generation.
module rxd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rxd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          fire,
  input  rxd_pkg::rxd_func_t            func,
  input  logic [7:0]                    data,
  output rxd_pkg::rxd_push_t            push
);

  logic [11:0] max_bytes;
  logic [15:0] wait_limit;

  logic        active,       active_next;
  logic [11:0] byte_count,   byte_count_next;
  logic [15:0] empty_polls,  empty_polls_next;
  logic [7:0]  held_byte,    held_byte_next;
  logic        held_valid,   held_valid_next;
  logic [7:0]  rssi_raw,     rssi_raw_next;
  logic [31:0] good_packets, good_packets_next;

  logic        pre_v;
  logic        fin;
  logic        fin_hv;
  logic [7:0]  fin_hb;
  logic [11:0] fin_cnt;
  logic        fin_glitch;
  logic [11:0] fin_len;
  logic        fin_byte_v;
  logic [11:0] cnt_inc;
  logic [15:0] polls_inc;
  logic [1:0]  k;
  rxd_pkg::rxd_result_t [rxd_pkg::RES_PER_ITEM-1:0] cand;
  logic        [rxd_pkg::RES_PER_ITEM-1:0]          cand_v;

  always_comb begin
    cnt_inc   = byte_count + 12'd1;
    polls_inc = empty_polls + 16'd1;

    active_next      = active;
    byte_count_next  = byte_count;
    empty_polls_next = empty_polls;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    rssi_raw_next    = rssi_raw;
    pre_v            = 1'b0;
    fin              = 1'b0;
    fin_hv           = held_valid;
    fin_hb           = held_byte;
    fin_cnt          = byte_count;

    unique case (func)
      rxd_pkg::FUNC_START: begin
        // Abandon any open packet and open a fresh one.
        rssi_raw_next    = data;
        active_next      = 1'b1;
        byte_count_next  = 12'd0;
        empty_polls_next = 16'd0;
        held_byte_next   = 8'd0;
        held_valid_next  = 1'b0;
        fin_hv           = 1'b0;
        fin_cnt          = 12'd0;
        fin              = (max_bytes == 12'd0);
      end
      rxd_pkg::FUNC_TIMEOUT: begin
        // Close as an empty packet.
        rssi_raw_next = data;
        fin_hv        = 1'b0;
        fin_cnt       = 12'd0;
        fin           = 1'b1;
      end
      rxd_pkg::FUNC_BYTE: begin
        if (active) begin
          if (data == 8'd0) begin
            fin = 1'b1;
          end else begin
            pre_v            = held_valid;
            held_byte_next   = data;
            held_valid_next  = 1'b1;
            byte_count_next  = cnt_inc;
            empty_polls_next = 16'd0;
            fin_hv           = 1'b1;
            fin_hb           = data;
            fin_cnt          = cnt_inc;
            fin              = (cnt_inc >= max_bytes);
          end
        end
      end
      rxd_pkg::FUNC_POLL: begin
        if (active) begin
          empty_polls_next = polls_inc;
          fin              = (polls_inc >= wait_limit);
        end
      end
      default: ;
    endcase

    // Drop a trailing glitch byte, otherwise deliver it before the summary.
    fin_glitch = fin_hv && ((fin_hb == rxd_pkg::GLITCH_ONE) ||
                            (fin_hb == rxd_pkg::GLITCH_TWO));
    fin_len    = fin_glitch ? (fin_cnt - 12'd1) : fin_cnt;
    fin_byte_v = fin && fin_hv && !fin_glitch;

    good_packets_next = good_packets;
    if (fin && (fin_len != 12'd0)) begin
      good_packets_next = good_packets + 32'd1;
    end

    if (fin) begin
      active_next      = 1'b0;
      byte_count_next  = 12'd0;
      empty_polls_next = 16'd0;
      held_byte_next   = 8'd0;
      held_valid_next  = 1'b0;
    end

    cand = '0;
    cand[0].kind         = rxd_pkg::KIND_PAYLOAD;
    cand[0].payload_byte = held_byte;
    cand[1].kind         = rxd_pkg::KIND_PAYLOAD;
    cand[1].payload_byte = fin_hb;
    cand[2].kind         = rxd_pkg::KIND_SUMMARY;
    cand[2].length       = fin_len;
    cand[2].rssi_dbm     = rxd_pkg::dbm_of(rssi_raw_next);
    cand[2].packet_total = good_packets_next;
    cand_v = {fin, fin_byte_v, pre_v};

    // Pack present results to the front and mark the final one.
    push = '0;
    k    = 2'd0;
    for (int i = 0; i < rxd_pkg::RES_PER_ITEM; i++) begin
      if (cand_v[i]) begin
        push.entry[k] = cand[i];
        k = k + 2'd1;
      end
    end
    for (int i = 0; i < rxd_pkg::RES_PER_ITEM; i++) begin
      push.entry[i].last = (k != 2'd0) && (2'(i) == (k - 2'd1));
    end
    push.count = fire ? k : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes    <= rxd_pkg::MAX_BYTES_RESET;
      wait_limit   <= rxd_pkg::WAIT_LIMIT_RESET;
      active       <= 1'b0;
      byte_count   <= 12'd0;
      empty_polls  <= 16'd0;
      held_byte    <= 8'd0;
      held_valid   <= 1'b0;
      rssi_raw     <= rxd_pkg::RSSI_UNKNOWN;
      good_packets <= 32'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rxd_pkg::REG_MAX_BYTES:  max_bytes  <= cfg_data[11:0];
          rxd_pkg::REG_WAIT_LIMIT: wait_limit <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (fire) begin
        active       <= active_next;
        byte_count   <= byte_count_next;
        empty_polls  <= empty_polls_next;
        held_byte    <= held_byte_next;
        held_valid   <= held_valid_next;
        rssi_raw     <= rssi_raw_next;
        good_packets <= good_packets_next;
      end
    end
  end

endmodule

[sv/rxd_result_fifo.sv]
// Small result queue: takes up to three results a cycle, gives one.
module rxd_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  rxd_pkg::rxd_push_t   push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rxd_pkg::rxd_result_t out_data
);

  rxd_pkg::rxd_result_t mem [rxd_pkg::FIFO_DEPTH];

  logic [rxd_pkg::FIFO_AW-1:0] wr_ptr;
  logic [rxd_pkg::FIFO_AW-1:0] rd_ptr;
  logic [rxd_pkg::FIFO_AW:0]   count;
  logic                        pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (rxd_pkg::FIFO_AW + 1)'(rxd_pkg::FIFO_DEPTH -
                                                       rxd_pkg::RES_PER_ITEM));

  always_ff @(posedge clk) begin
    for (int i = 0; i < rxd_pkg::RES_PER_ITEM; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr + rxd_pkg::FIFO_AW'(i)] <= push.entry[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rxd_pkg::FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + rxd_pkg::FIFO_AW'(1);
      end
      count <= count + (rxd_pkg::FIFO_AW + 1)'(push.count) -
               (rxd_pkg::FIFO_AW + 1)'(pop);
    end
  end

endmodule
